[hdl/mwe_pkg.sv]
// mwe_pkg: types and constants shared by the microwire eeprom master
// item structs, sequencer state struct, phase encoding, frame constants
// no dependencies
`default_nettype none

package mwe_pkg;

  localparam int ADDR_W  = 6;
  localparam int WORD_W  = 16;
  localparam int FRAME_W = 3 + ADDR_W;
  localparam int SHIFT_W = FRAME_W + WORD_W;
  localparam int CNT_W   = 5;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // serial frames: start bit, opcode, address field
  localparam logic [FRAME_W-1:0] FRAME_EWEN = 9'b1_00_110000;
  localparam logic [FRAME_W-1:0] FRAME_EWDS = 9'b1_00_000000;
  localparam logic [2:0]         OP_READ    = 3'b110;
  localparam logic [2:0]         OP_WRITE   = 3'b101;

  localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_W);
  localparam logic [CNT_W-1:0] CNT_SHIFT = CNT_W'(SHIFT_W);
  localparam logic [CNT_W-1:0] CNT_WORD  = CNT_W'(WORD_W);

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b0000000001,
    PH_EN_BITS  = 10'b0000000010,
    PH_EN_GAP   = 10'b0000000100,
    PH_CMD_BITS = 10'b0000001000,
    PH_RX_BITS  = 10'b0000010000,
    PH_CMD_END  = 10'b0000100000,
    PH_POLL     = 10'b0001000000,
    PH_POLL_END = 10'b0010000000,
    PH_DS_BITS  = 10'b0100000000,
    PH_DS_END   = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] write_data;
    logic              serial_data_in;
  } in_item_t;

  typedef struct packed {
    logic              chip_select;
    logic              serial_clock;
    logic              serial_data_out;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_data;
  } out_item_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   bit_cnt;
    logic [SHIFT_W-1:0] tx_shift;
    logic [WORD_W-1:0]  rx_shift;
    logic               is_write;
    logic               clk_level;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  data;
  } seq_state_t;

endpackage

`default_nettype wire

[hdl/mwe_step.sv]
// mwe_step: next-state and pin logic for one tick of the microwire sequencer
// purely combinational; uses mwe_pkg
`default_nettype none

module mwe_step
  import mwe_pkg::*;
(
  input  seq_state_t st,
  input  in_item_t   item,
  output seq_state_t st_nxt,
  output out_item_t  res
);

  seq_state_t cur;
  logic       last_bit;

  always_comb begin
    cur = st;
    // start while idle latches operands and runs the first enable tick now
    if (st.phase == PH_IDLE && (item.action == ACT_READ || item.action == ACT_WRITE)) begin
      cur.addr      = item.address;
      cur.data      = item.write_data;
      cur.is_write  = (item.action == ACT_WRITE);
      cur.tx_shift  = {FRAME_EWEN, {WORD_W{1'b0}}};
      cur.bit_cnt   = CNT_FRAME;
      cur.clk_level = 1'b0;
      cur.phase     = PH_EN_BITS;
    end
  end

  // transmit bit completes on the sk-high tick
  assign last_bit = cur.clk_level && (cur.bit_cnt == CNT_W'(1));

  always_comb begin
    st_nxt              = cur;
    res                 = '0;
    res.busy_res        = 1'b1;
    unique case (cur.phase)
      PH_EN_BITS, PH_CMD_BITS, PH_DS_BITS: begin
        res.chip_select     = 1'b1;
        res.serial_clock    = cur.clk_level;
        res.serial_data_out = cur.tx_shift[SHIFT_W-1];
        st_nxt.clk_level    = ~cur.clk_level;
        if (cur.clk_level) begin
          st_nxt.tx_shift = {cur.tx_shift[SHIFT_W-2:0], 1'b0};
          st_nxt.bit_cnt  = cur.bit_cnt - CNT_W'(1);
        end
        if (last_bit) begin
          unique case (cur.phase)
            PH_EN_BITS: st_nxt.phase = PH_EN_GAP;
            PH_DS_BITS: st_nxt.phase = PH_DS_END;
            default: begin
              if (cur.is_write) begin
                st_nxt.phase = PH_CMD_END;
              end else begin
                st_nxt.bit_cnt   = CNT_WORD;
                st_nxt.clk_level = 1'b0;
                st_nxt.phase     = PH_RX_BITS;
              end
            end
          endcase
        end
      end
      PH_EN_GAP: begin
        st_nxt.clk_level = 1'b0;
        st_nxt.phase     = PH_CMD_BITS;
        if (cur.is_write) begin
          st_nxt.tx_shift = {OP_WRITE, cur.addr, cur.data};
          st_nxt.bit_cnt  = CNT_SHIFT;
        end else begin
          st_nxt.tx_shift = {OP_READ, cur.addr, {WORD_W{1'b0}}};
          st_nxt.bit_cnt  = CNT_FRAME;
        end
      end
      PH_RX_BITS: begin
        res.chip_select  = 1'b1;
        res.serial_clock = cur.clk_level;
        st_nxt.clk_level = ~cur.clk_level;
        if (cur.clk_level) begin
          st_nxt.rx_shift = {cur.rx_shift[WORD_W-2:0], item.serial_data_in};
          st_nxt.bit_cnt  = cur.bit_cnt - CNT_W'(1);
          if (cur.bit_cnt == CNT_W'(1)) begin
            st_nxt.phase = PH_CMD_END;
          end
        end
      end
      PH_CMD_END: begin
        if (cur.is_write) begin
          st_nxt.clk_level = 1'b1;
          st_nxt.phase     = PH_POLL;
        end else begin
          st_nxt.tx_shift  = {FRAME_EWDS, {WORD_W{1'b0}}};
          st_nxt.bit_cnt   = CNT_FRAME;
          st_nxt.clk_level = 1'b0;
          st_nxt.phase     = PH_DS_BITS;
        end
      end
      PH_POLL: begin
        res.chip_select  = 1'b1;
        res.serial_clock = cur.clk_level;
        if (!cur.clk_level) begin
          st_nxt.clk_level = 1'b1;
        end else if (item.serial_data_in) begin
          st_nxt.phase = PH_POLL_END;
        end else begin
          st_nxt.clk_level = 1'b0;
        end
      end
      PH_POLL_END: begin
        st_nxt.tx_shift  = {FRAME_EWDS, {WORD_W{1'b0}}};
        st_nxt.bit_cnt   = CNT_FRAME;
        st_nxt.clk_level = 1'b0;
        st_nxt.phase     = PH_DS_BITS;
      end
      PH_DS_END: begin
        res.busy_res     = 1'b0;
        res.done_res     = 1'b1;
        st_nxt.clk_level = 1'b0;
        st_nxt.phase     = PH_IDLE;
      end
      default: begin
        // idle and any stray code
        res.busy_res     = 1'b0;
        st_nxt.clk_level = 1'b0;
        st_nxt.phase     = PH_IDLE;
      end
    endcase
    res.read_data = st_nxt.rx_shift;
  end

endmodule

`default_nettype wire

[hdl/microwire_eeprom_master.sv]
// microwire_eeprom_master: top level of the tick-driven microwire eeprom master
// holds sequencer state and the result register; uses mwe_pkg and mwe_step
`default_nettype none

// usage
//   each input item is one tick: action (plain tick, start read, start write),
//   the word address, the word to program and the sampled DO pin level.
//   each accepted item yields exactly one result item: CS, SK and DI pin
//   levels, busy, done and the last word read.
//   a start while idle sends write enable, then the read or write command,
//   polls DO after a write, and ends with write disable; done rises on the
//   final tick, on which busy is already low. starts while busy are ignored.
// latency and throughput
//   the result of an item is in the output register the cycle after it is
//   accepted; one item per cycle while the output is not stalled, set by the
//   combinational step logic between the state registers and the output register.
// stall
//   in_ready stays high while the output register is empty or being taken;
//   with out_ready low and a result pending, in_ready drops and the state
//   holds, so no tick is lost.
// reset
//   rst_n low (synchronous) returns the sequencer to idle, clears the shift
//   registers and counters and empties the output register.
module microwire_eeprom_master
  import mwe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  seq_state_t st_r, st_nxt;
  out_item_t  res;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       in_fire;

  // accept a tick whenever the output slot is free or draining this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  mwe_step u_step (
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // sequencer state advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.bit_cnt   <= '0;
      st_r.tx_shift  <= '0;
      st_r.rx_shift  <= '0;
      st_r.is_write  <= 1'b0;
      st_r.clk_level <= 1'b0;
      st_r.addr      <= '0;
      st_r.data      <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // done tick always leaves the sequencer idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.done_res |=> st_r.phase == PH_IDLE)
    else $error("done without return to idle");

  // a start seen while idle enters the enable frame
  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.phase == PH_IDLE &&
    (in_data.action == ACT_READ || in_data.action == ACT_WRITE)
    |=> st_r.phase == PH_EN_BITS && out_data.chip_select && out_data.busy_res)
    else $error("start not taken from idle");

  // DI and SK are quiet whenever chip select is low
  a_quiet_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.chip_select |->
    !out_data_r.serial_data_out && !out_data_r.serial_clock)
    else $error("pin activity with chip select low");

  // state holds while the output is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(st_r))
    else $error("state moved during stall");

endmodule

`default_nettype wire
